[hw/rtl/iarh64_pkg.sv]
// Shared types, prime table and the add-rotate step for the indexed hash.
package iarh64_pkg;

    localparam int WORD_W      = 64;
    localparam int ROT_AMT     = 7;
    localparam int ROUNDS_DEF  = 16;
    localparam int PRIME_COUNT = 27;
    localparam int PIDX_W      = $clog2(PRIME_COUNT);

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [PIDX_W-1:0] t_pidx;

    // Running word plus the constant used by this step and the one used by the next.
    typedef struct packed {
        t_word acc;
        t_word ka;
        t_word kb;
    } t_mix;

    localparam t_pidx LAST_PIDX = t_pidx'(PRIME_COUNT - 1);

    function automatic t_word prime_lookup(input t_pidx idx);
        t_word p;
        case (idx)
            5'd0:    p = 64'd538404559390855907;
            5'd1:    p = 64'd3805450411483076243;
            5'd2:    p = 64'd14708983389484784737;
            5'd3:    p = 64'd17195658974718141529;
            5'd4:    p = 64'd13245550289197498483;
            5'd5:    p = 64'd941416883125616461;
            5'd6:    p = 64'd5612982853315651507;
            5'd7:    p = 64'd4425188701120728451;
            5'd8:    p = 64'd1243719584255937337;
            5'd9:    p = 64'd13226440087791218581;
            5'd10:   p = 64'd5457430076438826907;
            5'd11:   p = 64'd4252286348012823599;
            5'd12:   p = 64'd12192003767930684759;
            5'd13:   p = 64'd6352987505094611413;
            5'd14:   p = 64'd7524584683149350093;
            5'd15:   p = 64'd15024612497464916197;
            5'd16:   p = 64'd5330929197429877007;
            5'd17:   p = 64'd12085737423030207737;
            5'd18:   p = 64'd13047231448031613839;
            5'd19:   p = 64'd17893104092742596429;
            5'd20:   p = 64'd3665815096395488329;
            5'd21:   p = 64'd5164402960129843169;
            5'd22:   p = 64'd2076469291307250377;
            5'd23:   p = 64'd8494890768520301029;
            5'd24:   p = 64'd10484743222427856449;
            5'd25:   p = 64'd11655765399976318403;
            5'd26:   p = 64'd17620121305513338553;
            default: p = '0;
        endcase
        return p;
    endfunction

    // acc + k + rotl(acc), wrapping
    function automatic t_word mix_step(input t_word acc, input t_word k);
        t_word rot;
        rot = {acc[WORD_W-1-ROT_AMT:0], acc[WORD_W-1 -: ROT_AMT]};
        return acc + k + rot;
    endfunction

endpackage

[hw/rtl/iarh64_idx.sv]
// Front end: index reduction mod 27, prime lookup and the initial mixing step.
module iarh64_idx (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  iarh64_pkg::t_word  i_value,
    input  iarh64_pkg::t_word  i_index,
    output logic               o_valid,
    output iarh64_pkg::t_mix   o_mix
);
    import iarh64_pkg::*;

    localparam int STAGES     = 7;
    localparam int FOLD9_BIAS = 513;   // 27 * 19, covers the largest high part

    logic [STAGES-1:0] r_vld;

    logic [19:0] r_s1, n_s1;
    logic [18:0] r_s2, n_s2;
    logic [10:0] r_s3, n_s3;
    logic [7:0]  r_s4, n_s4;
    logic        r_ones1, r_ones2, r_ones3, r_ones4;
    t_pidx       r_r1, r_r2, n_r1, n_r2;
    t_word       r_p1, r_p2;
    t_word       r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    t_mix        r_mix, n_mix;
    logic [7:0]  s_m;

    // 2^18 == 1 mod 27: sum of 18-bit chunks
    assign n_s1 = 20'(i_index[17:0]) + 20'(i_index[35:18])
                + 20'(i_index[53:36]) + 20'(i_index[63:54]);
    assign n_s2 = 19'(r_s1[17:0]) + 19'(r_s1[19:18]);
    // 2^9 == -1 mod 27
    assign n_s3 = 11'(r_s2[8:0]) + 11'(FOLD9_BIAS) - 11'(r_s2[18:9]);
    // 2^6 == 10 mod 27
    assign n_s4 = 8'(r_s3[5:0]) + 8'({r_s3[10:6], 3'b000}) + 8'({r_s3[10:6], 1'b0});

    always_comb begin
        s_m = r_s4;
        if (s_m >= 8'd216) s_m = s_m - 8'd216;
        if (s_m >= 8'd108) s_m = s_m - 8'd108;
        if (s_m >= 8'd54)  s_m = s_m - 8'd54;
        if (s_m >= 8'd27)  s_m = s_m - 8'd27;
        n_r1 = t_pidx'(s_m);
        // all-ones index: index + 1 wraps to zero
        if (r_ones4 || n_r1 == LAST_PIDX) begin
            n_r2 = '0;
        end else begin
            n_r2 = n_r1 + t_pidx'(1);
        end
    end

    always_comb begin
        n_mix.acc = mix_step(r_v6, r_p1);
        n_mix.ka  = r_p1;
        n_mix.kb  = r_p2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1    <= n_s1;
            r_ones1 <= &i_index;
            r_v1    <= i_value;
            r_s2    <= n_s2;
            r_ones2 <= r_ones1;
            r_v2    <= r_v1;
            r_s3    <= n_s3;
            r_ones3 <= r_ones2;
            r_v3    <= r_v2;
            r_s4    <= n_s4;
            r_ones4 <= r_ones3;
            r_v4    <= r_v3;
            r_r1    <= n_r1;
            r_r2    <= n_r2;
            r_v5    <= r_v4;
            r_p1    <= prime_lookup(r_r1);
            r_p2    <= prime_lookup(r_r2);
            r_v6    <= r_v5;
            r_mix   <= n_mix;
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_mix   = r_mix;

endmodule

[hw/rtl/iarh64_cell.sv]
// One half-round cell: acc + k + rotl7(acc), then swaps the two primes for the next cell.
module iarh64_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  iarh64_pkg::t_mix  i_mix,
    output logic              o_valid,
    output iarh64_pkg::t_mix  o_mix
);
    import iarh64_pkg::*;

    logic r_valid;
    t_mix r_mix, n_mix;

    always_comb begin
        n_mix.acc = mix_step(i_mix.acc, i_mix.ka);
        n_mix.ka  = i_mix.kb;
        n_mix.kb  = i_mix.ka;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mix <= n_mix;
        end
    end

    assign o_valid = r_valid;
    assign o_mix   = r_mix;

endmodule

[hw/rtl/indexed_add_rotate_hash64_unit.sv]
// Top level of the indexed add-rotate 64-bit hash pipeline.
//
// Takes one request per cycle while o_stall is low (value, function index)
// and returns one 64-bit hash per request, in order. Throughput is one
// request per clock while the output is not stalled, given by the fully
// pipelined chain: seven front-end stages (index mod 27 in folds, prime
// lookup, first mixing step) then 2*ROUNDS identical cells, each doing one
// 64-bit add-rotate step and passing the word and both primes on. The last
// cell's register is the output register. A stall on the output freezes the
// whole pipeline and is reflected on o_stall. No state survives between
// requests; reset only clears the valid bits.
module indexed_add_rotate_hash64_unit #(
    parameter int ROUNDS = iarh64_pkg::ROUNDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request side
    input  logic               i_valid,
    output logic               o_stall,
    input  iarh64_pkg::t_word  i_value_in,
    input  iarh64_pkg::t_word  i_function_index,
    // result side
    output logic               o_valid,
    input  logic               i_stall,
    output iarh64_pkg::t_word  o_hash_out
);
    import iarh64_pkg::*;

    localparam int CELLS = 2 * ROUNDS;

    logic s_en;
    logic s_vld [0:CELLS];
    t_mix s_mix [0:CELLS];

    // Whole pipeline moves together unless a finished hash is held off.
    assign s_en    = !(o_valid && i_stall);
    assign o_stall = !s_en;

    iarh64_idx u_idx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (i_valid),
        .i_value (i_value_in),
        .i_index (i_function_index),
        .o_valid (s_vld[0]),
        .o_mix   (s_mix[0])
    );

    // Cells alternate first and second prime by swapping them each step.
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        iarh64_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en),
            .i_valid (s_vld[g]),
            .i_mix   (s_mix[g]),
            .o_valid (s_vld[g+1]),
            .o_mix   (s_mix[g+1])
        );
    end

    assign o_valid    = s_vld[CELLS];
    assign o_hash_out = s_mix[CELLS].acc;

endmodule

[tb/indexed_add_rotate_hash64_unit_tb.sv]
// Self-checking testbench for the indexed add-rotate 64-bit hash unit.
module indexed_add_rotate_hash64_unit_tb;

    typedef iarh64_pkg::t_word t_word;

    localparam int ROUNDS      = 16;
    localparam int LATENCY     = 7 + 2 * ROUNDS;
    localparam int N_PRIMES    = 27;
    localparam int ROT         = 7;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_PER_PH = 212;
    localparam int NUM_DIR     = 16;

    // Our own copy of the constant table, indexed by function index mod 27
    localparam t_word HASH_PRIMES [N_PRIMES] = '{
        64'd538404559390855907,   64'd3805450411483076243,  64'd14708983389484784737,
        64'd17195658974718141529, 64'd13245550289197498483, 64'd941416883125616461,
        64'd5612982853315651507,  64'd4425188701120728451,  64'd1243719584255937337,
        64'd13226440087791218581, 64'd5457430076438826907,  64'd4252286348012823599,
        64'd12192003767930684759, 64'd6352987505094611413,  64'd7524584683149350093,
        64'd15024612497464916197, 64'd5330929197429877007,  64'd12085737423030207737,
        64'd13047231448031613839, 64'd17893104092742596429, 64'd3665815096395488329,
        64'd5164402960129843169,  64'd2076469291307250377,  64'd8494890768520301029,
        64'd10484743222427856449, 64'd11655765399976318403, 64'd17620121305513338553
    };

    // Directed requests. No hash can be read off by eye, so every row goes
    // through the predictor.
    typedef struct packed {
        t_word value;
        t_word findex;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{64'h0000_0000_0000_0000, 64'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0},
        // largest index: index+1 wraps to zero, second prime is entry 0
        '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
        // last table entry, second prime wraps round the table
        '{64'h0000_0000_0000_0001, 64'd26},
        '{64'h8000_0000_0000_0000, 64'd27},
        '{64'h5555_5555_5555_5555, 64'd25},
        '{64'hAAAA_AAAA_AAAA_AAAA, 64'd1},
        '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE},
        '{64'h8000_0000_0000_0001, 64'd53},
        '{64'h0000_0000_0000_007F, 64'd54},
        // top seven bits come round in the rotate
        '{64'hFE00_0000_0000_0000, 64'd13},
        '{64'h0123_4567_89AB_CDEF, 64'h8000_0000_0000_0000},
        '{64'hFEDC_BA98_7654_3210, 64'h0000_0001_0000_0000},
        '{64'hDEAD_BEEF_CAFE_F00D, 64'd2},
        '{64'hDEAD_BEEF_CAFE_F00D, 64'd3}
    };

    logic  i_clk            = 1'b0;
    logic  i_rst_n          = 1'b0;
    logic  i_valid          = 1'b0;
    logic  o_stall;
    t_word i_value_in       = '0;
    t_word i_function_index = '0;
    logic  o_valid;
    logic  i_stall          = 1'b0;
    t_word o_hash_out;

    t_word hash_expect_q [$];
    t_word exp_hash;
    int    tx_idle_pct  = 0;
    int    rx_idle_pct  = 0;
    int    n_mismatch   = 0;
    int    n_hashes     = 0;
    int    n_requests   = 0;
    int    idle_cycles  = 0;
    logic  any_accept;

    indexed_add_rotate_hash64_unit #(
        .ROUNDS(ROUNDS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_value_in      (i_value_in),
        .i_function_index(i_function_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hash_out      (o_hash_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_word rotl7(input t_word w);
        return (w << ROT) | (w >> (64 - ROT));
    endfunction

    function automatic t_word hash_predict(input t_word value, input t_word findex);
        t_word nxt;
        t_word p1;
        t_word p2;
        t_word acc;
        nxt = findex + 64'd1;   // wraps in 64 bits before the reduction
        p1  = HASH_PRIMES[findex % N_PRIMES];
        p2  = HASH_PRIMES[nxt % N_PRIMES];
        acc = value + p1 + rotl7(value);
        for (int r = 0; r < ROUNDS; r++) begin
            acc = acc + p1 + rotl7(acc);
            acc = acc + p2 + rotl7(acc);
        end
        return acc;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return t_word'(1) << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_word rand_index();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_word'($urandom_range(0, 80));
            4, 5:       return '1 - t_word'($urandom_range(0, 60));
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    task automatic note_mismatch(input string what, input t_word want, input t_word got);
        if (n_mismatch < 10)
            $display("mismatch (%s): expected %h, got %h", what, want, got);
        n_mismatch++;
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Both handshakes, the scoreboard and the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            any_accept = 1'b0;
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                any_accept = 1'b1;
                n_hashes++;
                if (hash_expect_q.size() == 0) begin
                    note_mismatch("unexpected hash", '0, o_hash_out);
                end else begin
                    exp_hash = hash_expect_q.pop_front();
                    if (o_hash_out !== exp_hash)
                        note_mismatch("hash_out", exp_hash, o_hash_out);
                end
            end
            if (i_valid === 1'b1 && o_stall === 1'b0) begin
                any_accept = 1'b1;
                hash_expect_q.push_back(hash_predict(i_value_in, i_function_index));
            end
            if (any_accept) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // Offer one request, with random idle cycles ahead of it, and hold it
    // until it is taken.
    task automatic send_request(input t_word value, input t_word findex);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_value_in       <= value;
        i_function_index <= findex;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        n_requests++;
    endtask

    // Sender holds off until every outstanding hash has come back.
    task automatic drain_hashes();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (hash_expect_q.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_ROWS[i])
            send_request(DIR_ROWS[i].value, DIR_ROWS[i].findex);
        drain_hashes();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin tx_idle_pct = 24; rx_idle_pct <= 78; end
                1:       begin tx_idle_pct = 78; rx_idle_pct <= 24; end
                default: begin tx_idle_pct = 0;  rx_idle_pct <= 0;  end
            endcase
            for (int n = 0; n < RAND_PER_PH; n++)
                send_request(rand_word(), rand_index());
            drain_hashes();
        end

        repeat (LATENCY + 10) @(posedge i_clk);

        $display("ran %0d requests (%0d directed) under idle mixes 24/78, 78/24 and 0/0",
                 n_requests, NUM_DIR);
        $display("checked %0d hashes, %0d mismatches", n_hashes, n_mismatch);
        if (n_mismatch == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
